// ===== design/rhh_pkg.sv =====
// Shared types, constants and codes for the Robin Hood hash table.
`timescale 1ns / 1ps
package rhh_pkg;

    localparam int SLOTS      = 1024;
    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int SIZE_W     = 11;
    localparam int KCNT_W     = $clog2(KEY_BITS);
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;
    localparam logic [SIZE_W-1:0] SIZE_CAP   = SIZE_W'(SLOTS);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CLR,
        BK_F_RD,
        BK_F_CHK,
        BK_P_RD,
        BK_P_CHK,
        BK_R_RD,
        BK_R_CHK,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]            operation;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } request_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        logic                  status;
        logic [SIZE_W-1:0]     item_count;
    } result_t;

    typedef struct packed {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_AW-1:0]    home;
    } job_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [SLOT_AW-1:0]    probe_len;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

endpackage

// ===== design/rhh_front.sv =====
// Front end: takes requests and computes the home slot with a bit-serial modulo.
`timescale 1ns / 1ps
module rhh_front
    import rhh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  request_t          request,
    input  logic              hold,
    input  logic [SIZE_W-1:0] eff_size,
    output logic              front_busy,
    output logic              job_valid,
    output job_t              job,
    input  logic              job_ready
);

    front_state_t        st_reg, st_next;
    logic [KCNT_W-1:0]   cnt_reg, cnt_next;
    logic [KEY_BITS-1:0] shift_reg, shift_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    request_t            req_reg, req_next;
    logic [SIZE_W:0]     trial;

    assign front_busy = (st_reg != FR_IDLE) || hold;
    assign job_valid  = (st_reg == FR_PUSH);
    assign job.op     = op_t'(req_reg.operation);
    assign job.key    = req_reg.key;
    assign job.value  = req_reg.value;
    assign job.home   = rem_reg[SLOT_AW-1:0];

    // State and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= FR_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        req_reg   <= req_next;
    end

    // One quotient bit per cycle; the remainder always stays below the size.
    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        req_next   = req_reg;
        trial      = {rem_reg, shift_reg[KEY_BITS-1]};
        if (trial >= {1'b0, eff_size})
        begin
            trial = trial - {1'b0, eff_size};
        end
        case (st_reg)
            FR_IDLE:
            begin
                if (start && !hold)
                begin
                    req_next   = request;
                    shift_next = request.key;
                    rem_next   = '0;
                    cnt_next   = '0;
                    st_next    = FR_DIV;
                end
            end
            FR_DIV:
            begin
                rem_next   = trial[SIZE_W-1:0];
                shift_next = {shift_reg[KEY_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == KCNT_W'(KEY_BITS - 1))
                begin
                    st_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (job_ready)
                begin
                    st_next = FR_IDLE;
                end
            end
            default:
            begin
                st_next = FR_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rhh_queue.sv =====
// Two-entry queue between the front end and the table engine.
`timescale 1ns / 1ps
module rhh_queue
    import rhh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  job_t push_job,
    output logic push_ready,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop
);

    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_job    = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ===== design/rhh_back.sv =====
// Table engine: probe walks, Robin Hood placement, backward-shift removal and clearing.
`timescale 1ns / 1ps
module rhh_back
    import rhh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_clear,
    input  logic [SIZE_W-1:0] eff_size,
    input  logic              job_valid,
    input  job_t              job,
    output logic              job_pop,
    output logic              clearing,
    output logic              result_valid,
    output result_t           result
);

    slot_t mem [SLOTS];
    slot_t rdata_reg;

    back_state_t           st_reg, st_next;
    logic [SLOT_AW-1:0]    clr_reg, clr_next;
    logic                  rep_reg, rep_next;
    logic [SIZE_W-1:0]     count_reg, count_next;
    logic [SLOT_AW-1:0]    idx_reg, idx_next;
    logic [SLOT_AW-1:0]    nxt_reg, nxt_next;
    logic [SIZE_W-1:0]     probe_reg, probe_next;
    job_t                  job_reg, job_next;
    logic [KEY_BITS-1:0]   ckey_reg, ckey_next;
    logic [VALUE_BITS-1:0] cval_reg, cval_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] vout_reg, vout_next;
    logic                  status_reg, status_next;

    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    slot_t              wr_data;
    logic [SLOT_AW-1:0] rd_addr;
    logic [SLOT_AW-1:0] idx_inc;
    logic [SLOT_AW-1:0] nxt_inc;

    assign clearing          = (st_reg == BK_CLR);
    assign result_valid      = (st_reg == BK_DONE);
    assign result.found      = found_reg;
    assign result.value_out  = vout_reg;
    assign result.status     = status_reg;
    assign result.item_count = count_reg;

    // Wrapping successors of the current and look-ahead slots.
    assign idx_inc = ({1'b0, idx_reg} + 1'b1 >= eff_size) ? '0 : idx_reg + 1'b1;
    assign nxt_inc = ({1'b0, nxt_reg} + 1'b1 >= eff_size) ? '0 : nxt_reg + 1'b1;

    // Slot memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control registers; reset starts a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BK_CLR;
            clr_reg   <= '0;
            rep_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_clear)
        begin
            st_reg    <= BK_CLR;
            clr_reg   <= '0;
            rep_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            clr_reg   <= clr_next;
            rep_reg   <= rep_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        nxt_reg    <= nxt_next;
        probe_reg  <= probe_next;
        job_reg    <= job_next;
        ckey_reg   <= ckey_next;
        cval_reg   <= cval_next;
        found_reg  <= found_next;
        vout_reg   <= vout_next;
        status_reg <= status_next;
    end

    // Operation sequencer.
    always_comb
    begin
        st_next     = st_reg;
        clr_next    = clr_reg;
        rep_next    = rep_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        nxt_next    = nxt_reg;
        probe_next  = probe_reg;
        job_next    = job_reg;
        ckey_next   = ckey_reg;
        cval_next   = cval_reg;
        found_next  = found_reg;
        vout_next   = vout_reg;
        status_next = status_reg;
        job_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rdata_reg;
        rd_addr     = idx_reg;
        case (st_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop     = 1'b1;
                    job_next    = job;
                    found_next  = 1'b0;
                    vout_next   = '0;
                    status_next = 1'b0;
                    idx_next    = job.home;
                    probe_next  = '0;
                    if (job.op == OP_CLEAR)
                    begin
                        clr_next = '0;
                        rep_next = 1'b1;
                        st_next  = BK_CLR;
                    end
                    else
                    begin
                        st_next = BK_F_RD;
                    end
                end
            end
            BK_CLR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_reg;
                wr_data       = '0;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == SLOT_AW'(SLOTS - 1))
                begin
                    count_next = '0;
                    st_next    = rep_reg ? BK_DONE : BK_IDLE;
                    rep_next   = 1'b0;
                end
            end
            BK_F_RD:
            begin
                st_next = BK_F_CHK;
            end
            BK_F_CHK:
            begin
                if (rdata_reg.valid && rdata_reg.key == job_reg.key)
                begin
                    // Key present.
                    found_next = 1'b1;
                    case (job_reg.op)
                        OP_INSERT:
                        begin
                            wr_en         = 1'b1;
                            wr_data.value = job_reg.value;
                            st_next       = BK_DONE;
                        end
                        OP_REMOVE:
                        begin
                            vout_next  = rdata_reg.value;
                            nxt_next   = idx_inc;
                            probe_next = SIZE_W'(1);
                            st_next    = BK_R_RD;
                        end
                        default:
                        begin
                            vout_next = rdata_reg.value;
                            st_next   = BK_DONE;
                        end
                    endcase
                end
                else if (!rdata_reg.valid || {1'b0, rdata_reg.probe_len} < probe_reg
                         || probe_reg + 1'b1 == eff_size)
                begin
                    // Key absent.
                    if (job_reg.op == OP_INSERT)
                    begin
                        if (count_reg >= eff_size)
                        begin
                            status_next = 1'b1;
                            st_next     = BK_DONE;
                        end
                        else
                        begin
                            ckey_next  = job_reg.key;
                            cval_next  = job_reg.value;
                            idx_next   = job_reg.home;
                            probe_next = '0;
                            st_next    = BK_P_RD;
                        end
                    end
                    else
                    begin
                        st_next = BK_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    probe_next = probe_reg + 1'b1;
                    st_next    = BK_F_RD;
                end
            end
            BK_P_RD:
            begin
                st_next = BK_P_CHK;
            end
            BK_P_CHK:
            begin
                if (!rdata_reg.valid)
                begin
                    wr_en      = 1'b1;
                    wr_data    = {1'b1, ckey_reg, probe_reg[SLOT_AW-1:0], cval_reg};
                    count_next = count_reg + 1'b1;
                    st_next    = BK_DONE;
                end
                else
                begin
                    // A richer resident trades places with the carried entry.
                    if (probe_reg > {1'b0, rdata_reg.probe_len})
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {1'b1, ckey_reg, probe_reg[SLOT_AW-1:0], cval_reg};
                        ckey_next  = rdata_reg.key;
                        cval_next  = rdata_reg.value;
                        probe_next = {1'b0, rdata_reg.probe_len} + 1'b1;
                    end
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                    end
                    idx_next = idx_inc;
                    st_next  = BK_P_RD;
                end
            end
            BK_R_RD:
            begin
                rd_addr = nxt_reg;
                st_next = BK_R_CHK;
            end
            BK_R_CHK:
            begin
                wr_en = 1'b1;
                if (!rdata_reg.valid || rdata_reg.probe_len == '0 || probe_reg == eff_size)
                begin
                    wr_data.valid = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    st_next = BK_DONE;
                end
                else
                begin
                    // Pull the follower back one slot.
                    wr_data.probe_len = rdata_reg.probe_len - 1'b1;
                    idx_next          = nxt_reg;
                    nxt_next          = nxt_inc;
                    probe_next        = probe_reg + 1'b1;
                    st_next           = BK_R_RD;
                end
            end
            BK_DONE:
            begin
                st_next = BK_IDLE;
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // The occupancy never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= SIZE_CAP)
        else $error("occupancy above slot count");

    // A result shows for a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !result_valid)
        else $error("result held more than one cycle");

    // No request leaves the queue while a clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !job_pop)
        else $error("request taken during clearing");

    // Insert refusal implies the key was not found.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status) |-> !result.found)
        else $error("full status on a found key");
`endif

endmodule

// ===== design/robin_hood_hash_table.sv =====
// Top level of the Robin Hood hash table: register port, front end, queue and engine.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its result appears one cycle long
// on result with result_valid, and the receiver cannot hold it off, so it must take it in
// that cycle. The front end reduces each key modulo size bit-serially, which overlaps with
// the engine's work on the previous request. The engine visits each slot with a read state
// and a check state on its slot memory: a lookup walks its probe run, an insert adds its
// placement walk and a remove its shift run. Clear and any write of table_size run a
// clearing pass over all 1024 slots, as does reset; busy stays high during the pass. With
// short probe runs the request rate is bounded by the modulo unit, which takes a new
// request only after it has pushed the last one into the queue.
module robin_hood_hash_table
    import rhh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    input  request_t    request,
    output logic        busy,
    output logic        result_valid,
    output result_t     result
);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] eff_size;
    logic              cfg_write;
    logic              cfg_clear;
    logic              front_busy;
    logic              clearing;
    logic              fq_valid, fq_ready;
    job_t              fq_job;
    logic              qb_valid, qb_pop;
    job_t              qb_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_clear = cfg_write && (paddr == 2'd0);
    assign prdata    = (paddr == 2'd0) ? {{(32 - SIZE_W){1'b0}}, size_reg} : '0;
    assign busy      = front_busy;

    // Size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_clear)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // Clamp the size to the usable range.
    always_comb
    begin
        eff_size = size_reg;
        if (size_reg < SIZE_MIN)
        begin
            eff_size = SIZE_MIN;
        end
        else if (size_reg > SIZE_CAP)
        begin
            eff_size = SIZE_CAP;
        end
    end

    rhh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .hold       (clearing),
        .eff_size   (eff_size),
        .front_busy (front_busy),
        .job_valid  (fq_valid),
        .job        (fq_job),
        .job_ready  (fq_ready)
    );

    rhh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_job   (fq_job),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_job    (qb_job),
        .pop        (qb_pop)
    );

    rhh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_clear    (cfg_clear),
        .eff_size     (eff_size),
        .job_valid    (qb_valid),
        .job          (qb_job),
        .job_pop      (qb_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the Robin Hood hash table: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
    import rhh_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 60;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    request_t    request;
    logic        busy;
    logic        result_valid;
    result_t     result;

    robin_hood_hash_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // Shadow copy of the table contents and its size register.
    logic                  shadow_valid [SLOTS];
    logic [KEY_BITS-1:0]   shadow_key   [SLOTS];
    int                    shadow_dist  [SLOTS];
    logic [VALUE_BITS-1:0] shadow_value [SLOTS];
    int                    shadow_count;
    logic [SIZE_W-1:0]     size_reg;

    result_t pending_results[$];
    int      error_count;
    int      idle_cycles;

    // Directed stimulus row: request plus an optional typed-in result.
    typedef struct {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        bit                    typed;
        result_t               want;
    } lookup_row_t;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void empty_shadow();
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
        end
        shadow_count = 0;
    endfunction

    function automatic int live_size();
        int n;
        n = int'(size_reg);
        if (n < 2) n = 2;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    // Applies one request to the shadow table and returns the result it should give.
    function automatic result_t hash_apply(request_t r);
        result_t               res;
        int                    n;
        int                    idx;
        int                    where;
        int                    probe;
        int                    nxt;
        int                    td;
        bit                    hit;
        logic [KEY_BITS-1:0]   ck;
        logic [KEY_BITS-1:0]   tk;
        logic [VALUE_BITS-1:0] cv;
        logic [VALUE_BITS-1:0] tv;
        res   = '0;
        n     = live_size();
        hit   = 1'b0;
        where = 0;
        if (r.operation == OP_CLEAR)
        begin
            empty_shadow();
        end
        else
        begin
            // Probe from home until an empty slot or a richer resident.
            idx = int'(r.key % 32'(n));
            for (probe = 0; probe < n; probe++)
            begin
                if (!shadow_valid[idx]) break;
                if (shadow_key[idx] == r.key)
                begin
                    hit   = 1'b1;
                    where = idx;
                    break;
                end
                if (shadow_dist[idx] < probe) break;
                idx = (idx + 1 >= n) ? 0 : idx + 1;
            end
            res.found = hit;
            if (r.operation == OP_LOOKUP)
            begin
                if (hit) res.value_out = shadow_value[where];
            end
            else if (r.operation == OP_INSERT)
            begin
                if (hit)
                begin
                    shadow_value[where] = r.value;
                end
                else if (shadow_count >= n)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    // Place the new key, trading places with richer residents.
                    ck    = r.key;
                    cv    = r.value;
                    idx   = int'(r.key % 32'(n));
                    probe = 0;
                    for (int s = 0; s < n; s++)
                    begin
                        if (!shadow_valid[idx])
                        begin
                            shadow_valid[idx] = 1'b1;
                            shadow_key[idx]   = ck;
                            shadow_dist[idx]  = probe;
                            shadow_value[idx] = cv;
                            shadow_count++;
                            break;
                        end
                        if (probe > shadow_dist[idx])
                        begin
                            tk = shadow_key[idx];
                            tv = shadow_value[idx];
                            td = shadow_dist[idx];
                            shadow_key[idx]   = ck;
                            shadow_dist[idx]  = probe;
                            shadow_value[idx] = cv;
                            ck    = tk;
                            cv    = tv;
                            probe = td;
                        end
                        idx = (idx + 1 >= n) ? 0 : idx + 1;
                        probe++;
                    end
                end
            end
            else if (hit)
            begin
                // Remove with backward shift of the following displaced entries.
                res.value_out = shadow_value[where];
                idx = where;
                nxt = (idx + 1 >= n) ? 0 : idx + 1;
                for (int s = 1; s < n; s++)
                begin
                    if (!shadow_valid[nxt] || shadow_dist[nxt] == 0) break;
                    shadow_key[idx]   = shadow_key[nxt];
                    shadow_value[idx] = shadow_value[nxt];
                    shadow_dist[idx]  = shadow_dist[nxt] - 1;
                    idx = nxt;
                    nxt = (idx + 1 >= n) ? 0 : idx + 1;
                end
                shadow_valid[idx] = 1'b0;
                if (shadow_count > 0) shadow_count--;
            end
        end
        res.item_count = SIZE_W'(shadow_count);
        return res;
    endfunction

    // Register write followed by a read back of table_size.
    task automatic write_size(logic [SIZE_W-1:0] sz);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= 32'(sz);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        size_reg = sz;
        empty_shadow();
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(sz))
        begin
            $error("table_size read back: expected %0d, actual %0d", sz, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Let all results drain, then give the front end time to fall idle.
    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sends one request after a gap; typed results replace the predicted one.
    task automatic send_request(request_t r, int gap, bit typed, result_t want);
        result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        predicted = hash_apply(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 65) return 0;
        if (roll < 95) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    function automatic result_t mk_result(bit f, logic [VALUE_BITS-1:0] v, bit s, int cnt);
        result_t res;
        res.found      = f;
        res.value_out  = v;
        res.status     = s;
        res.item_count = SIZE_W'(cnt);
        return res;
    endfunction

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, result.found);
                    error_count++;
                end
                if (result.value_out !== want.value_out)
                begin
                    $error("value_out: expected %h, actual %h", want.value_out, result.value_out);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    error_count++;
                end
                if (result.item_count !== want.item_count)
                begin
                    $error("item_count: expected %0d, actual %0d", want.item_count,
                           result.item_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles where neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || psel)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        lookup_row_t           rows[$];
        logic [KEY_BITS-1:0]   key_pool[24];
        logic [SIZE_W-1:0]     sizes[$];
        request_t              r;
        int                    n;
        int                    per_phase;
        int                    roll;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        request     = '0;
        error_count = 0;
        size_reg    = SIZE_RESET;
        empty_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size: extremes, replace, collisions, remove, clear.
        rows.push_back('{OP_LOOKUP, 32'h0, 32'h0, 1'b1, mk_result(1'b0, '0, 1'b0, 0)});
        rows.push_back('{OP_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1,
                         mk_result(1'b0, '0, 1'b0, 1)});
        rows.push_back('{OP_LOOKUP, 32'h0, 32'h0, 1'b1,
                         mk_result(1'b1, 32'hFFFF_FFFF, 1'b0, 1)});
        rows.push_back('{OP_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b1,
                         mk_result(1'b0, '0, 1'b0, 2)});
        rows.push_back('{OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
                         mk_result(1'b1, '0, 1'b0, 2)});
        rows.push_back('{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1,
                         mk_result(1'b1, 32'h1234_5678, 1'b0, 2)});
        rows.push_back('{OP_INSERT, 32'd1021, 32'hA5A5_5A5A, 1'b0, '0});
        rows.push_back('{OP_INSERT, 32'd2042, 32'h5A5A_A5A5, 1'b0, '0});
        rows.push_back('{OP_INSERT, 32'd1, 32'h0000_0001, 1'b0, '0});
        rows.push_back('{OP_LOOKUP, 32'd2042, 32'h0, 1'b0, '0});
        rows.push_back('{OP_REMOVE, 32'h0, 32'h0, 1'b0, '0});
        rows.push_back('{OP_LOOKUP, 32'd2042, 32'h0, 1'b0, '0});
        rows.push_back('{OP_LOOKUP, 32'd1, 32'h0, 1'b0, '0});
        rows.push_back('{OP_REMOVE, 32'd77, 32'h0, 1'b0, '0});
        rows.push_back('{OP_CLEAR, 32'h0, 32'hFFFF_FFFF, 1'b1,
                         mk_result(1'b0, '0, 1'b0, 0)});
        rows.push_back('{OP_LOOKUP, 32'd2042, 32'h0, 1'b1, mk_result(1'b0, '0, 1'b0, 0)});
        foreach (rows[i])
        begin
            r.operation = rows[i].op;
            r.key       = rows[i].key;
            r.value     = rows[i].value;
            send_request(r, pick_gap(), rows[i].typed, rows[i].want);
        end
        start <= 1'b0;
        drain();

        // Full table at size 2: the third new key is refused.
        write_size(SIZE_MIN);
        rows.delete();
        rows.push_back('{OP_INSERT, 32'd4, 32'h11, 1'b1, mk_result(1'b0, '0, 1'b0, 1)});
        rows.push_back('{OP_INSERT, 32'd6, 32'h22, 1'b1, mk_result(1'b0, '0, 1'b0, 2)});
        rows.push_back('{OP_INSERT, 32'd5, 32'h33, 1'b1, mk_result(1'b0, '0, 1'b1, 2)});
        rows.push_back('{OP_LOOKUP, 32'd5, 32'h0, 1'b1, mk_result(1'b0, '0, 1'b0, 2)});
        rows.push_back('{OP_INSERT, 32'd6, 32'h44, 1'b1, mk_result(1'b1, '0, 1'b0, 2)});
        rows.push_back('{OP_REMOVE, 32'd4, 32'h0, 1'b1,
                         mk_result(1'b1, 32'h11, 1'b0, 1)});
        rows.push_back('{OP_LOOKUP, 32'd6, 32'h0, 1'b1,
                         mk_result(1'b1, 32'h44, 1'b0, 1)});
        foreach (rows[i])
        begin
            r.operation = rows[i].op;
            r.key       = rows[i].key;
            r.value     = rows[i].value;
            send_request(r, pick_gap(), rows[i].typed, rows[i].want);
        end
        start <= 1'b0;
        drain();

        // Random phases over several sizes, clamped extremes among them.
        sizes = {11'd0, 11'd3, 11'd5, 11'd7, 11'd2047, 11'd11, 11'd13, 11'd1, 11'd17,
                 11'd1024, 11'd31, 11'd8, 11'd1021, 11'd23, 11'd2};
        foreach (sizes[p])
        begin
            write_size(sizes[p]);
            n = live_size();
            per_phase = (n > 64) ? 40 : 118;
            for (int i = 0; i < 24; i++)
            begin
                roll = int'($urandom_range(0, 2));
                if (roll == 0) key_pool[i] = $urandom;
                else key_pool[i] = 32'($urandom_range(0, 5)) * 32'(n) +
                                   32'($urandom_range(0, 3));
            end
            for (int i = 0; i < per_phase; i++)
            begin
                roll = int'($urandom_range(0, 99));
                if (roll < 30) r.operation = OP_LOOKUP;
                else if (roll < 70) r.operation = OP_INSERT;
                else if (roll < 98) r.operation = OP_REMOVE;
                else r.operation = OP_CLEAR;
                r.key   = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 23)]
                                                     : $urandom;
                r.value = $urandom;
                send_request(r, pick_gap(), 1'b0, '0);
            end
            start <= 1'b0;
            drain();
        end

        // Final wait for stragglers, then the verdict.
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
